// File: rtl/core/bf3_pkg.sv
package bf3_pkg;

    localparam int PIX_W         = 16;
    localparam int SUM_W         = 20;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int ROW_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int TAPS          = 3;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;
    localparam int DIV9_MUL      = 29127;
    localparam int DIV9_SHIFT    = 18;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_sum_word;

endpackage

// File: rtl/core/box_filter_3x3_stream.sv
// Pipeline: once the pixel that completes its window is accepted, a result word
//   passes line-memory read, window sum, multiply, round and saturate registers.
// Throughput: one pixel per cycle unless the output holds back results, set by one
//   read and one write per cycle on each of the two line memories.
// Reset: row and column counters clear, width 640 and height 480 take effect,
//   pipeline empties; line memories are not cleared and need no clearing pass.
module box_filter_3x3_stream #(
    parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [bf3_pkg::PIX_W-1:0]         i_s_axis_tdata,   // [15:0] pixel_in
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bf3_pkg::PIX_W-1:0]         o_m_axis_tdata,   // [15:0] pixel_out
    output logic                              o_m_axis_tlast,   // frame_last
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bf3_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    function automatic logic [COL_W-1:0] width_last(input logic [FW_W-1:0] v);
        int w;
        w = int'(v);
        if (w < TAPS) w = TAPS;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return COL_W'(w - 1);
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [FH_W-1:0] v);
        int h;
        h = int'(v);
        if (h < TAPS) h = TAPS;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return ROW_W'(h - 1);
    endfunction

    logic [COL_W-1:0]        r_width_last, r_col, n_col;
    logic [ROW_W-1:0]        r_height_last, r_row, n_row;
    logic                    s_accept, cfg_accept, cfg_restart;
    logic                    emit0, last0;
    logic                    r_s1_valid, r_s1_emit, r_s1_last;
    logic [COL_W-1:0]        r_s1_col;
    logic signed [PIX_W-1:0] r_s1_pix;
    logic signed [PIX_W-1:0] rd_upper, rd_middle;
    logic signed [SUM_W-1:0] r_cs_old, r_cs_new, col_sum;
    logic                    s1_adv, s1_rdy, mean_ready;
    t_sum_word               sum_word;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign cfg_restart = cfg_accept &&
                         ((i_cfg_index == REG_FRAME_WIDTH) || (i_cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_last  <= width_last(FW_W'(WIDTH_RST));
            r_height_last <= height_last(FH_W'(HEIGHT_RST));
        end else if (cfg_accept) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width_last  <= width_last(i_cfg_data[FW_W-1:0]);
                REG_FRAME_HEIGHT: r_height_last <= height_last(i_cfg_data[FH_W-1:0]);
                default: ;
            endcase
        end
    end

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign emit0    = (r_row >= ROW_W'(TAPS - 1)) && (r_col >= COL_W'(TAPS - 1));
    assign last0    = (r_row == r_height_last) && (r_col == r_width_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (s_accept) begin
            if (r_col == r_width_last) begin
                n_col = '0;
                n_row = (r_row == r_height_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    bf3_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) u_upper (
        .i_clk   (i_clk),
        .i_re    (s_accept),
        .i_raddr (r_col),
        .o_rdata (rd_upper),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (rd_middle)
    );

    bf3_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) u_middle (
        .i_clk   (i_clk),
        .i_re    (s_accept),
        .i_raddr (r_col),
        .o_rdata (rd_middle),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix)
    );

    assign s1_adv          = r_s1_valid && (!r_s1_emit || mean_ready);
    assign s1_rdy          = !r_s1_valid || s1_adv;
    assign o_s_axis_tready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_valid <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_pix  <= $signed(i_s_axis_tdata);
            r_s1_col  <= r_col;
            r_s1_emit <= emit0;
            r_s1_last <= last0;
        end
    end

    assign col_sum      = SUM_W'(rd_upper) + SUM_W'(rd_middle) + SUM_W'(r_s1_pix);
    assign sum_word.sum = col_sum + r_cs_old + r_cs_new;
    assign sum_word.last = r_s1_last;

    // shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_old <= '0;
            r_cs_new <= '0;
        end else if (s1_adv) begin
            r_cs_old <= r_cs_new;
            r_cs_new <= col_sum;
        end
    end

    bf3_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid && r_s1_emit),
        .o_ready (mean_ready),
        .i_word  (sum_word),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pixel (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_width_last)
        else $error("column counter beyond row end");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_height_last)
        else $error("row counter beyond frame end");

    a_emit_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && emit0) |=> (r_s1_valid && r_s1_emit))
        else $error("window-complete pixel lost before sum stage");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && last0 && !cfg_restart) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after last pixel of frame");

endmodule

// File: rtl/core/bf3_line_mem.sv
module bf3_line_mem #(
    parameter int DEPTH  = bf3_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = 10
) (
    input  logic                             i_clk,
    input  logic                             i_re,
    input  logic [ADDR_W-1:0]                i_raddr,
    output logic signed [bf3_pkg::PIX_W-1:0] o_rdata,
    input  logic                             i_we,
    input  logic [ADDR_W-1:0]                i_waddr,
    input  logic signed [bf3_pkg::PIX_W-1:0] i_wdata
);
    import bf3_pkg::*;

    logic signed [PIX_W-1:0] mem [DEPTH];
    logic signed [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // forward a write that lands on the entry being read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= (i_we && (i_waddr == i_raddr)) ? i_wdata : mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bf3_mean.sv
module bf3_mean (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  bf3_pkg::t_sum_word               i_word,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [bf3_pkg::PIX_W-1:0] o_pixel,
    output logic                             o_last
);
    import bf3_pkg::*;

    localparam int PROD_W = SUM_W + 17;
    localparam int Q_W    = PROD_W - DIV9_SHIFT;
    localparam logic signed [16:0] MUL_K = 17'(DIV9_MUL);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (DIV9_SHIFT - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    logic                     r_a_valid, r_b_valid, r_o_valid;
    logic signed [SUM_W-1:0]  r_a_sum;
    logic                     r_a_last, r_b_last, r_o_last;
    logic signed [PROD_W-1:0] r_b_prod;
    logic signed [PIX_W-1:0]  r_o_pixel;
    logic                     o_rdy, b_rdy, a_rdy;
    logic signed [PROD_W-1:0] rounded;
    logic signed [Q_W-1:0]    quot;
    logic signed [PIX_W-1:0]  n_o_pixel;

    assign o_rdy   = !r_o_valid || i_ready;
    assign b_rdy   = !r_b_valid || o_rdy;
    assign a_rdy   = !r_a_valid || b_rdy;
    assign o_ready = a_rdy;

    assign rounded = r_b_prod + ROUND_BIAS;
    assign quot    = rounded[PROD_W-1:DIV9_SHIFT];

    always_comb begin
        if (quot > Q_MAX) begin
            n_o_pixel = PIX_W'(Q_MAX);
        end else if (quot < Q_MIN) begin
            n_o_pixel = PIX_W'(Q_MIN);
        end else begin
            n_o_pixel = quot[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_a_valid <= i_valid;
            end
            if (b_rdy) begin
                r_b_valid <= r_a_valid;
            end
            if (o_rdy) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_valid) begin
            r_a_sum  <= i_word.sum;
            r_a_last <= i_word.last;
        end
        if (b_rdy && r_a_valid) begin
            r_b_prod <= PROD_W'(r_a_sum) * PROD_W'(MUL_K);
            r_b_last <= r_a_last;
        end
        if (o_rdy && r_b_valid) begin
            r_o_pixel <= n_o_pixel;
            r_o_last  <= r_b_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;
    assign o_last  = r_o_last;

endmodule
